### hw/rtl/frms_pkg.sv
// Shared constants, types and codes of the frame RMS meter.
`timescale 1ns / 1ps
package frms_pkg;

   localparam int MAX_LEN    = 1024;
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = SAMPLE_W + 1;
   localparam int SQ_W       = 2 * SAMPLE_W - 1;
   localparam int CNT_W      = $clog2(MAX_LEN + 1);
   localparam int SUM_W      = SQ_W + $clog2(MAX_LEN);
   localparam int RMS_W      = 16;
   localparam int LEN_W      = 11;
   localparam int UNIT_W     = 2 * SAMPLE_W;
   localparam int SQRT_STEPS = UNIT_W / 2;
   localparam int STEP_W     = $clog2(SUM_W + 1);

   typedef enum logic [3:0] {
      ST_ACCUM = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_SQRT  = 4'b0100,
      ST_DONE  = 4'b1000
   } frms_state_type;

   // Frame totals including the word being presented.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
      logic             too_long;
   } frms_totals_type;

   typedef struct packed {
      logic [UNIT_W-1:0] diff;
      logic              ge;
   } frms_sub_type;

endpackage

### hw/rtl/frms_req_if.sv
// Input channel carrying one sample word and its frame-end flag.
`timescale 1ns / 1ps
interface frms_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [frms_pkg::SAMPLE_W-1:0] sample;
   logic                              frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink (input valid, input sample, input frame_end, output ready);
endinterface

### hw/rtl/frms_rsp_if.sv
// Result channel carrying one RMS word per frame.
`timescale 1ns / 1ps
interface frms_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [frms_pkg::RMS_W-1:0]   rms_value;
   logic [frms_pkg::LEN_W-1:0]   frame_length;
   logic                         too_long;

   modport source (output valid, output rms_value, output frame_length, output too_long,
                   input ready);
   modport sink (input valid, input rms_value, input frame_length, input too_long,
                 output ready);
endinterface

### hw/rtl/frms_accum.sv
// Sum-of-squares and sample-count accumulator of the current frame.
`timescale 1ns / 1ps
module frms_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic signed [frms_pkg::SAMPLE_W-1:0] sample,
   input  logic                                 frame_end,
   output frms_pkg::frms_totals_type            totals
);

   logic [frms_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [frms_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       over_ff, over_in;
   logic [frms_pkg::MAG_W-1:0] mag;
   logic [2*frms_pkg::MAG_W-1:0] product;

   always_comb begin
      if (sample[frms_pkg::SAMPLE_W-1]) begin
         mag = frms_pkg::MAG_W'(-$signed({sample[frms_pkg::SAMPLE_W-1], sample}));
      end else begin
         mag = frms_pkg::MAG_W'(sample);
      end
      product = mag * mag;

      totals.sum      = sum_ff;
      totals.count    = count_ff;
      totals.too_long = over_ff;
      // Once the frame is full, further samples only mark the overflow.
      if (count_ff < frms_pkg::CNT_W'(frms_pkg::MAX_LEN)) begin
         totals.sum   = sum_ff + frms_pkg::SUM_W'(product[frms_pkg::SQ_W-1:0]);
         totals.count = count_ff + frms_pkg::CNT_W'(1);
      end else begin
         totals.too_long = 1'b1;
      end

      sum_in   = sum_ff;
      count_in = count_ff;
      over_in  = over_ff;
      if (take) begin
         if (frame_end) begin
            sum_in   = '0;
            count_in = '0;
            over_in  = 1'b0;
         end else begin
            sum_in   = totals.sum;
            count_in = totals.count;
            over_in  = totals.too_long;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         over_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         over_ff  <= over_in;
      end
   end

endmodule

### hw/rtl/frms_cmpsub.sv
// Shared compare-and-subtract unit used by both division and square root.
`timescale 1ns / 1ps
module frms_cmpsub (
   input  logic [frms_pkg::UNIT_W-1:0] op_a,
   input  logic [frms_pkg::UNIT_W-1:0] op_b,
   output frms_pkg::frms_sub_type      result
);

   logic [frms_pkg::UNIT_W:0] wide;

   always_comb begin
      wide        = {1'b0, op_a} - {1'b0, op_b};
      result.diff = wide[frms_pkg::UNIT_W-1:0];
      result.ge   = ~wide[frms_pkg::UNIT_W];
   end

endmodule

### hw/rtl/frms_seq.sv
// Sequencer: restoring division then digit-by-digit square root, and result register.
`timescale 1ns / 1ps
module frms_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  frms_pkg::frms_totals_type       totals,
   output logic                            accepting,
   output logic [frms_pkg::UNIT_W-1:0]     op_a,
   output logic [frms_pkg::UNIT_W-1:0]     op_b,
   input  frms_pkg::frms_sub_type          sub,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [frms_pkg::RMS_W-1:0]      rsp_rms,
   output logic [frms_pkg::LEN_W-1:0]      rsp_len,
   output logic                            rsp_long
);

   frms_pkg::frms_state_type state_ff, state_in;
   logic [frms_pkg::STEP_W-1:0] step_ff, step_in;
   logic [frms_pkg::SUM_W-1:0]  work_ff, work_in;
   logic [frms_pkg::CNT_W-1:0]  div_ff, div_in;
   logic [frms_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [frms_pkg::UNIT_W-1:0] val_ff, val_in;
   logic [frms_pkg::UNIT_W-1:0] root_ff, root_in;
   logic [frms_pkg::UNIT_W-1:0] bit_ff, bit_in;
   logic                        long_ff, long_in;
   logic                        out_valid_ff, out_valid_in;
   logic [frms_pkg::RMS_W-1:0]  out_rms_ff, out_rms_in;
   logic [frms_pkg::LEN_W-1:0]  out_len_ff, out_len_in;
   logic                        out_long_ff, out_long_in;
   logic [frms_pkg::CNT_W-1:0]  rem_shift;
   logic                        slot_free;

   assign accepting = (state_ff == frms_pkg::ST_ACCUM);
   assign rsp_valid = out_valid_ff;
   assign rsp_rms   = out_rms_ff;
   assign rsp_len   = out_len_ff;
   assign rsp_long  = out_long_ff;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign rem_shift = {rem_ff[frms_pkg::CNT_W-2:0], work_ff[frms_pkg::SUM_W-1]};

   always_comb begin
      op_a = val_ff;
      op_b = root_ff | bit_ff;
      if (state_ff == frms_pkg::ST_DIV) begin
         op_a = frms_pkg::UNIT_W'(rem_shift);
         op_b = frms_pkg::UNIT_W'(div_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      work_in      = work_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      val_in       = val_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      long_in      = long_ff;
      out_valid_in = out_valid_ff;
      out_rms_in   = out_rms_ff;
      out_len_in   = out_len_ff;
      out_long_in  = out_long_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         frms_pkg::ST_ACCUM: begin
            if (start) begin
               work_in  = totals.sum;
               div_in   = totals.count;
               long_in  = totals.too_long;
               rem_in   = '0;
               step_in  = '0;
               state_in = frms_pkg::ST_DIV;
            end
         end
         frms_pkg::ST_DIV: begin
            // One quotient bit per cycle; the dividend shifts out as quotient shifts in.
            rem_in  = sub.ge ? sub.diff[frms_pkg::CNT_W-1:0] : rem_shift;
            work_in = {work_ff[frms_pkg::SUM_W-2:0], sub.ge};
            step_in = step_ff + frms_pkg::STEP_W'(1);
            if (step_ff == frms_pkg::STEP_W'(frms_pkg::SUM_W - 1)) begin
               step_in  = '0;
               state_in = frms_pkg::ST_SQRT;
            end
         end
         frms_pkg::ST_SQRT: begin
            if (step_ff == '0) begin
               // The mean is below 2^31, so the quotient fits the unit width.
               val_in  = work_ff[frms_pkg::UNIT_W-1:0];
               root_in = '0;
               bit_in  = frms_pkg::UNIT_W'(1) << (frms_pkg::UNIT_W - 2);
               step_in = frms_pkg::STEP_W'(1);
            end else begin
               if (sub.ge) begin
                  val_in  = sub.diff;
                  root_in = (root_ff >> 1) | bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in  = bit_ff >> 2;
               step_in = step_ff + frms_pkg::STEP_W'(1);
               if (step_ff == frms_pkg::STEP_W'(frms_pkg::SQRT_STEPS)) begin
                  state_in = frms_pkg::ST_DONE;
               end
            end
         end
         frms_pkg::ST_DONE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_rms_in   = root_ff[frms_pkg::RMS_W-1:0];
               out_len_in   = frms_pkg::LEN_W'(div_ff);
               out_long_in  = long_ff;
               step_in      = '0;
               state_in     = frms_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = frms_pkg::ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frms_pkg::ST_ACCUM;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      val_ff      <= val_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      long_ff     <= long_in;
      out_rms_ff  <= out_rms_in;
      out_len_ff  <= out_len_in;
      out_long_ff <= out_long_in;
   end

endmodule

### hw/rtl/frame_rms_meter_unit.sv
// Top level of the frame RMS meter.
`timescale 1ns / 1ps
// Within a frame the meter takes one sample word every cycle. The word that
// carries frame_end is followed by a stretch in which req_chan.ready is low
// while the sequencer works. Restoring division of the 41-bit sum of squares
// by the sample count comes first. The square root then loads the mean and
// runs 16 iterations, and the result register is loaded last. All of this runs
// on a single shared 32-bit compare-and-subtract unit. The result register
// lets the next frame start while a finished result is still waiting on
// rsp_chan. If that result is still waiting when the following frame's root
// is ready, the meter holds until rsp_chan takes it. Samples past 1024 in a
// frame are dropped and flagged with too_long.
module frame_rms_meter_unit (
   input  logic     clock,
   input  logic     reset,
   frms_req_if.sink   req_chan,
   frms_rsp_if.source rsp_chan
);

   frms_pkg::frms_totals_type    totals;
   frms_pkg::frms_sub_type       sub;
   logic [frms_pkg::UNIT_W-1:0]  op_a;
   logic [frms_pkg::UNIT_W-1:0]  op_b;
   logic                         accepting;
   logic                         take;

   assign req_chan.ready = accepting;
   assign take           = req_chan.valid && accepting;

   frms_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .sample    (req_chan.sample),
      .frame_end (req_chan.frame_end),
      .totals    (totals)
   );

   frms_cmpsub u_cmpsub (
      .op_a   (op_a),
      .op_b   (op_b),
      .result (sub)
   );

   frms_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (take && req_chan.frame_end),
      .totals    (totals),
      .accepting (accepting),
      .op_a      (op_a),
      .op_b      (op_b),
      .sub       (sub),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_rms   (rsp_chan.rms_value),
      .rsp_len   (rsp_chan.frame_length),
      .rsp_long  (rsp_chan.too_long)
   );

endmodule

### hw/rtl/frms_checker.sv
// Port-level checks of the frame RMS meter and their binding to the top level.
`timescale 1ns / 1ps
module frms_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_frame_end,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [frms_pkg::RMS_W-1:0]   rsp_rms_value,
   input logic [frms_pkg::LEN_W-1:0]   rsp_frame_length,
   input logic                         rsp_too_long
);

   // A waiting result word must not change or vanish.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rms_value)
         && $stable(rsp_frame_length) && $stable(rsp_too_long))
      else $error("result word changed while stalled");

   // Closing a frame starts the divide and square root, so input must stall.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_end |=> !req_ready)
      else $error("input still ready after a frame end word");

   // Every frame holds at least one sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_length != '0)
      else $error("result reports an empty frame");

   // The root of a Q2.30 mean is at most full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms_value <= frms_pkg::RMS_W'(32768))
      else $error("rms value above full scale");

   // A dropped sample only happens in a frame filled to the limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_frame_length == frms_pkg::LEN_W'(frms_pkg::MAX_LEN))
      else $error("too_long set on a short frame");

endmodule

bind frame_rms_meter_unit frms_checker u_frms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_frame_end    (req_chan.frame_end),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_rms_value    (rsp_chan.rms_value),
   .rsp_frame_length (rsp_chan.frame_length),
   .rsp_too_long     (rsp_chan.too_long)
);
